// File: sv/tem_pkg.sv
package tem_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int CNT_W       = COUNT_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int ABS_W       = SAMPLE_BITS + 1 + COUNT_BITS;
  localparam int NRM_W       = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  localparam int DOT_W       = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_W      = 2 * NRM_W;
  localparam int DSQ_W       = 2 * DOT_W;
  localparam int RHS_W       = 2 * DOT_W + 30;
  localparam int LHS_W       = PROD_W + 30;
  localparam int CMP_W       = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef struct packed {
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        mean_sq_error;
    logic [15:0]        mean_abs_error;
    logic [15:0]        peak_abs_error;
    logic signed [15:0] cosine_sim;
    logic [20:0]        element_total;
    logic               count_overflow;
  } out_item_t;

  typedef struct packed {
    logic accum;
    logic start;
    logic step;
    logic clear;
  } tem_cmd_t;

  typedef struct packed {
    logic done;
  } tem_sts_t;

endpackage

// File: sv/tem_ctrl.sv
module tem_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tem_pkg::tem_cmd_t    cmd,
  input  tem_pkg::tem_sts_t    sts
);
  import tem_pkg::*;

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       acc_go;

  assign in_stall  = (state_r != S_ACC);
  assign acc_go    = in_valid && (state_r == S_ACC);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        cmd.accum = acc_go;
        if (acc_go && in_last) begin
          cmd.start = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.step = 1'b1;
        if (sts.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clear = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_ACC;
    else        state_r <= state_nxt;
  end
endmodule

// File: sv/tem_dp.sv
module tem_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tem_pkg::in_item_t    in_data,
  input  tem_pkg::tem_cmd_t    cmd,
  output tem_pkg::tem_sts_t    sts,
  output tem_pkg::out_item_t   out_data
);
  import tem_pkg::*;

  // phases of the result sequencer
  localparam logic [2:0] P_LOAD = 3'd0;
  localparam logic [2:0] P_DIV  = 3'd1;
  localparam logic [2:0] P_INIT = 3'd2;
  localparam logic [2:0] P_COS  = 3'd3;
  localparam logic [2:0] P_FIN  = 3'd4;

  logic [SQ_W-1:0]         sq_r;
  logic [ABS_W-1:0]        ab_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [NRM_W-1:0]        na_r, nb_r;
  logic [15:0]             mx_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r;

  logic signed [SAMPLE_BITS-1:0]   a_s, b_s;
  logic signed [SAMPLE_BITS:0]     d_s;
  logic [SAMPLE_BITS:0]            ad;
  logic [2*SAMPLE_BITS+1:0]        sqd;
  logic signed [2*SAMPLE_BITS-1:0] pab, paa, pbb;
  logic                            room;

  assign a_s  = in_data.a_value[SAMPLE_BITS-1:0];
  assign b_s  = in_data.b_value[SAMPLE_BITS-1:0];
  assign d_s  = {a_s[SAMPLE_BITS-1], a_s} - {b_s[SAMPLE_BITS-1], b_s};
  assign ad   = d_s[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_s) : d_s;
  assign sqd  = ad * ad;
  assign pab  = a_s * b_s;
  assign paa  = a_s * a_s;
  assign pbb  = b_s * b_s;
  assign room = !cnt_r[COUNT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sq_r <= '0; ab_r <= '0; dot_r <= '0; na_r <= '0; nb_r <= '0;
      mx_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.accum) begin
      if (room) begin
        sq_r  <= sq_r + SQ_W'(sqd);
        ab_r  <= ab_r + ABS_W'(ad);
        dot_r <= dot_r + DOT_W'(pab);
        na_r  <= na_r + NRM_W'($unsigned(paa));
        nb_r  <= nb_r + NRM_W'($unsigned(pbb));
        if (16'(ad) > mx_r) mx_r <= 16'(ad);
        cnt_r <= cnt_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // result sequencer: bit-serial dividers with shift-add multipliers alongside,
  // then cosine one bit a cycle from incremental squares
  logic [2:0]        ph_r;
  logic [5:0]        bit_r;
  logic [SQ_W-1:0]   qs_r;
  logic [CNT_W:0]    rs_r;
  logic [ABS_W-1:0]  qa_r;
  logic [CNT_W:0]    ra_r;
  logic [PROD_W-1:0] pa_r;
  logic [NRM_W-1:0]  pb_r;
  logic [PROD_W-1:0] prod_r;
  logic [DSQ_W-1:0]  ma_r;
  logic [DOT_W-1:0]  mb_r;
  logic [DSQ_W-1:0]  dsq_r;
  logic [CMP_W-1:0]  tq_r, xq_r, yq_r;
  logic [CMP_W-1:0]  cand, rhs;
  logic [3:0]        k_r;
  logic [15:0]       lo_r;
  logic              done_r;
  logic [DOT_W-1:0]  dmag;
  logic [CNT_W:0]    rs_sh, ra_sh;

  assign dmag  = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign rs_sh = {rs_r[CNT_W-1:0], qs_r[SQ_W-1]};
  assign ra_sh = {ra_r[CNT_W-1:0], qa_r[ABS_W-1]};
  assign rhs   = CMP_W'(dsq_r) << 30;
  assign cand  = tq_r + (xq_r << 1) + yq_r;
  assign sts.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_LOAD; done_r <= 1'b0;
    end else if (cmd.start) begin
      ph_r <= P_LOAD; done_r <= 1'b0;
    end else if (cmd.step && !done_r) begin
      unique case (ph_r)
        P_LOAD: begin
          qs_r <= sq_r; qa_r <= ab_r; rs_r <= '0; ra_r <= '0;
          bit_r <= 6'(SQ_W);
          pa_r <= PROD_W'(na_r); pb_r <= nb_r; prod_r <= '0;
          ma_r <= DSQ_W'(dmag); mb_r <= dmag; dsq_r <= '0;
          ph_r <= P_DIV;
        end
        P_DIV: begin
          if (rs_sh >= (CNT_W+1)'(cnt_r)) begin
            rs_r <= rs_sh - (CNT_W+1)'(cnt_r);
            qs_r <= {qs_r[SQ_W-2:0], 1'b1};
          end else begin
            rs_r <= rs_sh;
            qs_r <= {qs_r[SQ_W-2:0], 1'b0};
          end
          if (bit_r <= 6'(ABS_W)) begin
            if (ra_sh >= (CNT_W+1)'(cnt_r)) begin
              ra_r <= ra_sh - (CNT_W+1)'(cnt_r);
              qa_r <= {qa_r[ABS_W-2:0], 1'b1};
            end else begin
              ra_r <= ra_sh;
              qa_r <= {qa_r[ABS_W-2:0], 1'b0};
            end
          end
          if (pb_r[0]) prod_r <= prod_r + pa_r;
          pa_r <= pa_r << 1;
          pb_r <= pb_r >> 1;
          if (mb_r[0]) dsq_r <= dsq_r + ma_r;
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
          bit_r <= bit_r - 1'b1;
          if (bit_r == 6'd1) ph_r <= (na_r == '0 || nb_r == '0) ? P_FIN : P_INIT;
        end
        P_INIT: begin
          tq_r <= '0;
          xq_r <= '0;
          yq_r <= CMP_W'(prod_r) << 30;
          k_r  <= 4'd15;
          lo_r <= '0;
          ph_r <= P_COS;
        end
        P_COS: begin
          if (cand <= rhs) begin
            tq_r      <= cand;
            xq_r      <= (xq_r + yq_r) >> 1;
            lo_r[k_r] <= 1'b1;
          end else begin
            xq_r <= xq_r >> 1;
          end
          yq_r <= yq_r >> 2;
          k_r  <= k_r - 1'b1;
          if (k_r == 4'd0) ph_r <= P_FIN;
        end
        P_FIN: begin
          done_r <= 1'b1;
        end
        default: ph_r <= P_LOAD;
      endcase
    end else if (cmd.clear) begin
      done_r <= 1'b0;
    end
  end

  always_comb begin
    out_data.mean_sq_error  = (cnt_r == '0) ? '0 : qs_r[31:0];
    out_data.mean_abs_error = (cnt_r == '0) ? '0 : qa_r[15:0];
    out_data.peak_abs_error = mx_r;
    if (na_r == '0 || nb_r == '0)
      out_data.cosine_sim = '0;
    else if (dot_r[DOT_W-1])
      out_data.cosine_sim = 16'(-lo_r);
    else
      out_data.cosine_sim = (lo_r > 16'd32767) ? 16'sd32767 : $signed(lo_r);
    out_data.element_total  = 21'(cnt_r);
    out_data.count_overflow = ovf_r;
  end
endmodule

// File: sv/tensor_error_metrics.sv
// Element-wise error metrics between two tensors. One element pair is taken
// per cycle while accumulating; on the item marked last the block divides both
// sums by the count (bit-serial, with the norm and dot squares formed by
// shift-add multipliers alongside) and then finds cosine similarity one result
// bit a cycle. The sequencer steps through load, divide, init, cosine and
// finish phases before the result is offered (init and cosine are skipped when
// either norm is zero), no new item is taken until that result has been taken,
// and the next item can follow on the next cycle. State then clears.
module tensor_error_metrics (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tem_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tem_pkg::out_item_t    out_data
);
  import tem_pkg::*;

  tem_cmd_t cmd;
  tem_sts_t sts;

  tem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_last(in_data.last), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  tem_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );
endmodule
